>>> rtl/ptsb_pkg.sv
// Package: shared constants, register indexes and result type for the tick scheduler
package ptsb_pkg;

  // Task count and field widths
  localparam int NTASKS    = 7;
  localparam int PERIOD_W  = 17;
  localparam int TICK_W    = 17;
  localparam int DELAY_W   = 16;
  localparam int FAIL_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 17;

  // Timing constants
  localparam int BASE_INTERVAL_MS = 1000;
  localparam int WRAP_TICKS       = 86400;

  // Backoff product: (fail_count + 1) times the base interval
  localparam int MUL_W = FAIL_W + 1 + $clog2(BASE_INTERVAL_MS + 1);

  // Reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RESET [NTASKS] =
    '{17'd30, 17'd60, 17'd3600, 17'd300, 17'd600, 17'd30, 17'd5};
  localparam logic [DELAY_W-1:0] BACKOFF_CAP_RESET = 16'd10000;
  localparam logic [NTASKS-1:0]  PENDING_RESET     = 7'h50;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEALTH_PERIOD         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIENT_SYNC_PERIOD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_PERIOD           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_EVENT_PERIOD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRUNE_PERIOD          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLIENT_CONTROL_PERIOD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_PERIOD          = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_CAP_MS        = 3'd7;

  // One result transaction
  typedef struct packed {
    logic                dispatch_valid;
    logic [NTASKS-1:0]   task_mask;
    logic [DELAY_W-1:0]  tick_delay_ms;
    logic [FAIL_W-1:0]   failure_count;
  } ptsb_result_t;

endpackage

>>> rtl/ptsb_if.sv
// Interfaces: tick input channel and dispatch result channel

interface ptsb_in_if;
  logic valid;
  logic ready;
  logic dispatch_ok;

  modport source (output valid, output dispatch_ok, input ready);
  modport sink   (input valid, input dispatch_ok, output ready);
endinterface

interface ptsb_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  dispatch_valid;
  logic [ptsb_pkg::NTASKS-1:0]           task_mask;
  logic [ptsb_pkg::DELAY_W-1:0]          tick_delay_ms;
  logic [ptsb_pkg::FAIL_W-1:0]           failure_count;

  modport source (output valid, output dispatch_valid, output task_mask,
                  output tick_delay_ms, output failure_count, input ready);
  modport sink   (input valid, input dispatch_valid, input task_mask,
                  input tick_delay_ms, input failure_count, output ready);
endinterface

>>> rtl/ptsb_core.sv
// Scheduler core: config registers, tick/phase counters, pending mask and backoff
module ptsb_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ptsb_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [ptsb_pkg::CFG_W-1:0]           cfg_wdata,
  ptsb_in_if.sink                              in_ch,
  input  logic                                 res_ready,
  output logic                                 res_valid,
  output ptsb_pkg::ptsb_result_t               res
);

  logic [ptsb_pkg::PERIOD_W-1:0] period_r [ptsb_pkg::NTASKS];
  logic [ptsb_pkg::DELAY_W-1:0]  cap_r;
  logic [ptsb_pkg::TICK_W-1:0]   tick_r;
  logic [ptsb_pkg::TICK_W-1:0]   tick_nxt;
  logic [ptsb_pkg::PERIOD_W-1:0] phase_r   [ptsb_pkg::NTASKS];
  logic [ptsb_pkg::PERIOD_W-1:0] phase_nxt [ptsb_pkg::NTASKS];
  logic [ptsb_pkg::NTASKS-1:0]   pending_r;
  logic [ptsb_pkg::NTASKS-1:0]   pending_nxt;
  logic [ptsb_pkg::FAIL_W-1:0]   fail_r;
  logic [ptsb_pkg::FAIL_W-1:0]   fail_nxt;

  logic                          accept;
  logic [ptsb_pkg::NTASKS-1:0]   fire;
  logic [ptsb_pkg::NTASKS-1:0]   pend_now;
  logic                          dispatch;
  logic                          failed;
  logic                          wrap;
  logic [ptsb_pkg::FAIL_W:0]     fail_plus1;
  logic [ptsb_pkg::MUL_W-1:0]    backoff_prod;
  logic [ptsb_pkg::DELAY_W-1:0]  delay;

  assign in_ch.ready = res_ready;
  assign accept      = in_ch.valid && res_ready;
  assign res_valid   = accept;

  // Tick count and phase counters
  always_comb begin
    logic [ptsb_pkg::PERIOD_W-1:0] inc;
    tick_nxt = tick_r + ptsb_pkg::TICK_W'(1);
    wrap     = tick_nxt >= ptsb_pkg::TICK_W'(ptsb_pkg::WRAP_TICKS);
    for (int i = 0; i < ptsb_pkg::NTASKS; i++) begin
      inc          = phase_r[i] + ptsb_pkg::PERIOD_W'(1);
      fire[i]      = inc >= period_r[i];
      phase_nxt[i] = (fire[i] || wrap) ? '0 : inc;
    end
    if (wrap) begin
      tick_nxt = '0;
    end
  end

  // Pending mask and failure count
  always_comb begin
    pend_now    = pending_r | fire;
    dispatch    = pend_now != '0;
    failed      = dispatch && !in_ch.dispatch_ok;
    pending_nxt = (dispatch && in_ch.dispatch_ok) ? '0 : pend_now;
    if (!failed) begin
      fail_nxt = '0;
    end else if (fail_r != '1) begin
      fail_nxt = fail_r + ptsb_pkg::FAIL_W'(1);
    end else begin
      fail_nxt = fail_r;
    end
  end

  // Linear backoff, capped
  assign fail_plus1   = {1'b0, fail_nxt} + (ptsb_pkg::FAIL_W+1)'(1);
  assign backoff_prod = ptsb_pkg::MUL_W'(ptsb_pkg::BASE_INTERVAL_MS) *
                        ptsb_pkg::MUL_W'(fail_plus1);

  always_comb begin
    if (!failed) begin
      delay = ptsb_pkg::DELAY_W'(ptsb_pkg::BASE_INTERVAL_MS);
    end else if (backoff_prod > ptsb_pkg::MUL_W'(cap_r)) begin
      delay = cap_r;
    end else begin
      delay = backoff_prod[ptsb_pkg::DELAY_W-1:0];
    end
  end

  always_comb begin
    res.dispatch_valid = dispatch;
    res.task_mask      = dispatch ? pend_now : '0;
    res.tick_delay_ms  = delay;
    res.failure_count  = fail_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ptsb_pkg::NTASKS; i++) begin
        period_r[i] <= ptsb_pkg::PERIOD_RESET[i];
      end
      cap_r <= ptsb_pkg::BACKOFF_CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        ptsb_pkg::REG_BACKOFF_CAP_MS: begin
          cap_r <= cfg_wdata[ptsb_pkg::DELAY_W-1:0];
        end
        default: begin
          period_r[cfg_idx] <= cfg_wdata[ptsb_pkg::PERIOD_W-1:0];
        end
      endcase
    end
  end

  // Scheduler state, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= '0;
      pending_r <= ptsb_pkg::PENDING_RESET;
      fail_r    <= '0;
      for (int i = 0; i < ptsb_pkg::NTASKS; i++) begin
        phase_r[i] <= '0;
      end
    end else if (accept) begin
      tick_r    <= tick_nxt;
      pending_r <= pending_nxt;
      fail_r    <= fail_nxt;
      for (int i = 0; i < ptsb_pkg::NTASKS; i++) begin
        phase_r[i] <= phase_nxt[i];
      end
    end
  end

endmodule

>>> rtl/ptsb_outbuf.sv
// Result register with skid stage driving the result channel
module ptsb_outbuf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_valid,
  input  ptsb_pkg::ptsb_result_t res,
  output logic                   res_ready,
  ptsb_out_if.source             out_ch
);

  logic                   main_valid_r;
  ptsb_pkg::ptsb_result_t main_r;
  logic                   skid_valid_r;
  ptsb_pkg::ptsb_result_t skid_r;
  logic                   advance;

  assign res_ready = !skid_valid_r;
  assign advance   = !main_valid_r || out_ch.ready;

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (advance) begin
      main_valid_r <= skid_valid_r || res_valid;
      skid_valid_r <= 1'b0;
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (advance) begin
      main_r <= skid_valid_r ? skid_r : res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid          = main_valid_r;
  assign out_ch.dispatch_valid = main_r.dispatch_valid;
  assign out_ch.task_mask      = main_r.task_mask;
  assign out_ch.tick_delay_ms  = main_r.tick_delay_ms;
  assign out_ch.failure_count  = main_r.failure_count;

endmodule

>>> rtl/periodic_task_scheduler_backoff_unit.sv
// Top level: periodic task scheduler with capped linear retry backoff
// An accepted result goes to the main register, or to the skid stage while out_ch stalls.
// One tick per cycle while the skid stage is empty; scheduler state updates on accept.
// Input ready depends only on the registered skid stage, so one stalled result is absorbed.
// Reset (rst_n low, synchronous): counters and failure count clear, prune and power
// pending, periods and backoff cap return to their defaults, output channel empties.
module periodic_task_scheduler_backoff_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ptsb_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [ptsb_pkg::CFG_W-1:0]     cfg_wdata,
  ptsb_in_if.sink                        in_ch,
  ptsb_out_if.source                     out_ch
);

  logic                   res_valid;
  logic                   res_ready;
  ptsb_pkg::ptsb_result_t res;

  ptsb_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  ptsb_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_ch    (out_ch)
  );

  // A dispatch always carries a nonzero mask, and no dispatch carries none
  a_mask_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.dispatch_valid == (out_ch.task_mask != '0)))
    else $error("task_mask disagrees with dispatch_valid");

  // Failures only accumulate on a real dispatch
  a_fail_needs_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.failure_count != '0) |-> out_ch.dispatch_valid)
    else $error("failure count raised without a dispatch");

  // Zero failures means the base delay
  a_base_delay: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.failure_count == '0) |->
      (out_ch.tick_delay_ms == ptsb_pkg::DELAY_W'(ptsb_pkg::BASE_INTERVAL_MS)))
    else $error("delay differs from base interval with no failures");

endmodule
